>>> src/pe_base_relocation_parser_macros.svh
// Assertion macros for the base relocation parser.
// The enclosing module supplies clk and arst_n.
`ifndef PE_BASE_RELOCATION_PARSER_MACROS_SVH
`define PE_BASE_RELOCATION_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, a, b)
`define ASSERT_NEXT(lbl, a, b)
`endif
`endif

>>> src/pebr_pkg.sv
`timescale 1ns / 1ps
package pebr_pkg;

	localparam int unsigned DeltaW  = 64;
	localparam int unsigned OffsetW = 32;

	// register indexes
	localparam logic REG_DELTA    = 1'b0;
	localparam logic REG_RISCV_EN = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNKNOWN   = 2'd1;
	localparam logic [1:0] ST_UNALIGNED = 2'd2;

	// patch kinds
	localparam logic [2:0] KIND_HIGH16 = 3'd0;
	localparam logic [2:0] KIND_LOW16  = 3'd1;
	localparam logic [2:0] KIND_ADD32  = 3'd2;
	localparam logic [2:0] KIND_ADD64  = 3'd3;
	localparam logic [2:0] KIND_HI20   = 3'd4;

	// relocation entry types
	localparam logic [3:0] TY_ABSOLUTE = 4'd0;
	localparam logic [3:0] TY_HIGH     = 4'd1;
	localparam logic [3:0] TY_LOW      = 4'd2;
	localparam logic [3:0] TY_HIGHLOW  = 4'd3;
	localparam logic [3:0] TY_RV_HI20  = 4'd5;
	localparam logic [3:0] TY_RV_LO12I = 4'd7;
	localparam logic [3:0] TY_RV_LO12S = 4'd8;
	localparam logic [3:0] TY_DIR64    = 4'd10;

	localparam logic [31:0] MIN_BLOCK_SIZE = 32'd8;

	typedef struct packed {
		logic               patch_valid;
		logic [OffsetW-1:0] patch_offset;
		logic [2:0]         patch_kind;
		logic [DeltaW-1:0]  addend;
		logic               done_res;
		logic [1:0]         status;
	} res_t;

endpackage

>>> src/pe_base_relocation_parser.sv
`timescale 1ns / 1ps
// PE/COFF base relocation parser. Takes the relocation directory one 16-bit
// word per beat and gives a patch command for each entry that needs one, plus
// a done result with the run's status on the word marked last. One word is
// taken every cycle: the header and entry decode, the 32-bit offset add and
// the entry count update sit between the input handshake and the result
// register. A two-entry result buffer (result register plus skid register)
// lets words keep flowing while a result waits; input stalls only while both
// hold a result. Write delta and riscv_enable only while the block is idle.
`include "pe_base_relocation_parser_macros.svh"
module pe_base_relocation_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [pebr_pkg::DeltaW-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [15:0]                   table_word,
	input  logic                          last_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          patch_valid,
	output logic [pebr_pkg::OffsetW-1:0]  patch_offset,
	output logic [2:0]                    patch_kind,
	output logic [pebr_pkg::DeltaW-1:0]   addend,
	output logic                          done_res,
	output logic [1:0]                    status
);

	typedef enum logic [2:0] {
		PH_PAGE_LO = 3'd0,
		PH_PAGE_HI = 3'd1,
		PH_SIZE_LO = 3'd2,
		PH_SIZE_HI = 3'd3,
		PH_ENTRY   = 3'd4,
		PH_STOP    = 3'd5
	} phase_t;

	logic [pebr_pkg::DeltaW-1:0] delta_q;
	logic                        riscv_en_q;

	phase_t      phase_q, phase_d;
	logic [31:0] page_q, page_d;
	logic [15:0] size_lo_q, size_lo_d;
	logic [30:0] entries_q, entries_d;
	logic [1:0]  halt_q, halt_d;

	pebr_pkg::res_t res_d, main_q, skid_q;
	logic           main_valid_q, skid_valid_q;
	logic           has_res;
	logic           accept;
	logic           patch;
	logic           stop;
	logic [1:0]     stop_st;
	logic [2:0]     kind;
	logic [pebr_pkg::DeltaW-1:0] add;
	logic [31:0]    size;
	logic [30:0]    entries_dec;
	logic [31:0]    offset;
	logic [31:0]    d32;

	assign accept = in_valid && in_ready;
	assign in_ready = !skid_valid_q;
	assign d32 = delta_q[31:0];
	assign size = {table_word, size_lo_q};
	assign entries_dec = entries_q - 31'd1;
	assign offset = page_q + {20'd0, table_word[11:0]};

	always_comb begin
		patch   = 1'b0;
		stop    = 1'b0;
		stop_st = pebr_pkg::ST_OK;
		kind    = pebr_pkg::KIND_HIGH16;
		add     = '0;
		unique case (table_word[15:12])
			pebr_pkg::TY_ABSOLUTE: ;
			pebr_pkg::TY_HIGH: begin
				patch = 1'b1;
				kind  = pebr_pkg::KIND_HIGH16;
				add   = {48'd0, d32[31:16]};
			end
			pebr_pkg::TY_LOW: begin
				patch = 1'b1;
				kind  = pebr_pkg::KIND_LOW16;
				add   = {48'd0, d32[15:0]};
			end
			pebr_pkg::TY_HIGHLOW: begin
				patch = 1'b1;
				kind  = pebr_pkg::KIND_ADD32;
				add   = {32'd0, d32};
			end
			pebr_pkg::TY_DIR64: begin
				patch = 1'b1;
				kind  = pebr_pkg::KIND_ADD64;
				add   = delta_q;
			end
			pebr_pkg::TY_RV_HI20: begin
				if (riscv_en_q) begin
					patch = 1'b1;
					kind  = pebr_pkg::KIND_HI20;
					add   = {32'd0, d32};
				end else begin
					stop    = 1'b1;
					stop_st = pebr_pkg::ST_UNKNOWN;
				end
			end
			pebr_pkg::TY_RV_LO12I, pebr_pkg::TY_RV_LO12S: begin
				if (!riscv_en_q) begin
					stop    = 1'b1;
					stop_st = pebr_pkg::ST_UNKNOWN;
				end else if (delta_q[11:0] != 12'd0) begin
					stop    = 1'b1;
					stop_st = pebr_pkg::ST_UNALIGNED;
				end
			end
			default: begin
				stop    = 1'b1;
				stop_st = pebr_pkg::ST_UNKNOWN;
			end
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		page_d    = page_q;
		size_lo_d = size_lo_q;
		entries_d = entries_q;
		halt_d    = halt_q;
		has_res   = last_word;
		res_d     = '0;
		if (delta_q != '0) begin
			unique case (phase_q)
				PH_PAGE_LO: begin
					page_d  = {16'd0, table_word};
					phase_d = PH_PAGE_HI;
				end
				PH_PAGE_HI: begin
					page_d  = {table_word, page_q[15:0]};
					phase_d = PH_SIZE_LO;
				end
				PH_SIZE_LO: begin
					size_lo_d = table_word;
					phase_d   = PH_SIZE_HI;
				end
				PH_SIZE_HI: begin
					if (size < pebr_pkg::MIN_BLOCK_SIZE) begin
						phase_d   = PH_STOP;
						halt_d    = pebr_pkg::ST_OK;
						entries_d = '0;
					end else begin
						entries_d = size[31:1] - 31'd4;
						phase_d   = (size[31:1] != 31'd4) ? PH_ENTRY : PH_PAGE_LO;
					end
				end
				PH_ENTRY: begin
					res_d.patch_valid  = patch;
					res_d.patch_offset = patch ? offset : '0;
					res_d.patch_kind   = patch ? kind : '0;
					res_d.addend       = patch ? add : '0;
					has_res            = patch || last_word;
					if (stop) begin
						phase_d   = PH_STOP;
						halt_d    = stop_st;
						entries_d = '0;
					end else begin
						entries_d = entries_dec;
						if (entries_dec == '0) begin
							phase_d = PH_PAGE_LO;
						end
					end
				end
				default: ;
			endcase
		end
		res_d.done_res = last_word;
		res_d.status   = last_word ? halt_d : pebr_pkg::ST_OK;
		if (last_word) begin
			phase_d   = PH_PAGE_LO;
			page_d    = '0;
			size_lo_d = '0;
			entries_d = '0;
			halt_d    = pebr_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q      <= '0;
			riscv_en_q   <= 1'b0;
			phase_q      <= PH_PAGE_LO;
			page_q       <= '0;
			size_lo_q    <= '0;
			entries_q    <= '0;
			halt_q       <= pebr_pkg::ST_OK;
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
			main_q       <= '0;
			skid_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pebr_pkg::REG_DELTA:    delta_q    <= cfg_wdata;
					pebr_pkg::REG_RISCV_EN: riscv_en_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (accept) begin
				phase_q   <= phase_d;
				page_q    <= page_d;
				size_lo_q <= size_lo_d;
				entries_q <= entries_d;
				halt_q    <= halt_d;
			end
			// result buffer: main register feeds the port, skid catches a beat while it stalls
			if (main_valid_q && !out_ready) begin
				if (accept && has_res) begin
					skid_valid_q <= 1'b1;
					skid_q       <= res_d;
				end
			end else if (skid_valid_q) begin
				main_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
				main_q       <= skid_q;
			end else begin
				main_valid_q <= accept && has_res;
				if (accept && has_res) begin
					main_q <= res_d;
				end
			end
		end
	end

	assign out_valid    = main_valid_q;
	assign patch_valid  = main_q.patch_valid;
	assign patch_offset = main_q.patch_offset;
	assign patch_kind   = main_q.patch_kind;
	assign addend       = main_q.addend;
	assign done_res     = main_q.done_res;
	assign status       = main_q.status;

	`ASSERT_IMPLIES(a_skid_behind_main, skid_valid_q, main_valid_q)
	`ASSERT_IMPLIES(a_stop_no_entries, phase_q == PH_STOP, entries_q == '0)
	`ASSERT_IMPLIES(a_entry_has_count, phase_q == PH_ENTRY, entries_q != '0)
	`ASSERT_IMPLIES(a_status_on_done, out_valid && (status != pebr_pkg::ST_OK), done_res)
	`ASSERT_IMPLIES(a_idle_fields_zero, out_valid && !patch_valid,
		(patch_kind == '0) && (addend == '0) && (patch_offset == '0))
	`ASSERT_NEXT(a_last_clears, accept && last_word,
		(phase_q == PH_PAGE_LO) && (halt_q == pebr_pkg::ST_OK))

endmodule
